/* rtl/manchester_word_frame_encoder_defines.svh */
// assertion macros used by the encoder top level
`ifndef MANCHESTER_WORD_FRAME_ENCODER_DEFINES_SVH
`define MANCHESTER_WORD_FRAME_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MWFE_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");
`define MWFE_ASSERT_RST(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("assertion failed");
`else
`define MWFE_ASSERT(lbl, clk_s, rst_s, prop)
`define MWFE_ASSERT_RST(lbl, clk_s, prop)
`endif

`endif

/* rtl/mwfe_pkg.sv */
// shared types, constants and the cell pattern function of the encoder
package mwfe_pkg;

  localparam int unsigned WORD_W            = 16;
  localparam int unsigned CELLS_PER_WORD    = 40;
  localparam int unsigned CELL_CNT_W        = 6;
  localparam int unsigned FRAME_QUEUE_DEPTH = 8;
  localparam logic [5:0]  SYNC_CELLS        = 6'h38;

  // one queued word with its precomputed parity
  typedef struct packed {
    logic              last_word;
    logic              parity;
    logic [WORD_W-1:0] data_word;
  } word_entry_t;

  // queue fill status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // serializer status
  typedef struct packed {
    logic                  busy;
    logic [CELL_CNT_W-1:0] cell_cnt;
  } back_stat_t;

  // all 40 half-bit cells of a word, first cell in the msb
  function automatic logic [CELLS_PER_WORD-1:0] cell_frame(
    input logic [WORD_W-1:0] d,
    input logic              p
  );
    logic [CELLS_PER_WORD-1:0] f;
    f = '0;
    f[CELLS_PER_WORD-1 -: 6] = SYNC_CELLS;
    for (int i = 0; i < WORD_W; i++) begin
      f[2*i+3] = ~d[i];
      f[2*i+2] = d[i];
    end
    f[1] = ~p;
    f[0] = p;
    return f;
  endfunction

endpackage

/* rtl/manchester_word_frame_encoder.sv */
// top level of the manchester word frame encoder
//
// Each 16-bit word taken on the slave stream comes out as 40 half-bit
// Manchester cells on the master stream, one cell per transfer: six sync
// cells 1,1,1,0,0,0, then data bits 15 down to 0 as two cells each (0 as 1,0
// and 1 as 0,1), then the even-XOR parity bit coded the same way. tlast marks
// the fortieth cell of every word, tuser marks that cell when the word came
// in with tlast set. The serializer emits one cell per cycle while the sink
// takes it, and words stream with no gap between them. An input stage tags
// each word with its parity and hands it to a queue of FRAME_QUEUE_DEPTH
// words, so the source can deliver up to that many words (plus one in the
// input stage and one in the queue's head register) ahead of the line. An
// idle block carries a word's first cell through the input stage, the queue
// memory, the head register, the serializer's cells and the output register.
`include "manchester_word_frame_encoder_defines.svh"

module manchester_word_frame_encoder #(
  parameter int unsigned FRAME_QUEUE_DEPTH = mwfe_pkg::FRAME_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // word input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] data_word
  input  logic        s_tlast,   // last_word
  // cell output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] cell_level, [7:1] zero
  output logic        m_tlast,   // last_cell
  output logic        m_tuser    // end_of_message
);

  localparam int unsigned CNT_W = $clog2(FRAME_QUEUE_DEPTH + 1);

  logic                  push;
  mwfe_pkg::word_entry_t push_entry;
  logic                  pop;
  logic                  head_valid;
  mwfe_pkg::word_entry_t head;
  mwfe_pkg::queue_stat_t q_stat;
  mwfe_pkg::back_stat_t  b_stat;
  logic [CNT_W-1:0]      level;

  // front end: parity tagging and hand-off into the queue
  mwfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // word queue decoupling the input from the line
  mwfe_queue #(
    .DEPTH (FRAME_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .q_stat     (q_stat),
    .level      (level)
  );

  // back end: 40-cell serializer with output register
  mwfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .b_stat     (b_stat),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  // end of message only ever lands on a word's closing cell
  `MWFE_ASSERT(a_eom_on_last, clk, rst, m_tvalid && m_tuser |-> m_tlast)
  // the queue never holds more words than it has room for, checked from reset on
  `MWFE_ASSERT_RST(a_level_bound, clk, rst || (level <= CNT_W'(FRAME_QUEUE_DEPTH)))
  // an idle serializer sits at the first cell
  `MWFE_ASSERT(a_idle_cnt, clk, rst, !b_stat.busy |-> b_stat.cell_cnt == '0)
  // a word can only leave the queue's head when one is there
  `MWFE_ASSERT(a_pop_valid, clk, rst, pop |-> head_valid && !q_stat.empty)

endmodule

/* rtl/mwfe_front.sv */
// input stage: takes words and tags each with its parity
module mwfe_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mwfe_pkg::WORD_W-1:0]   s_tdata,
  input  logic                          s_tlast,
  input  mwfe_pkg::queue_stat_t         q_stat,
  output logic                          push,
  output mwfe_pkg::word_entry_t         push_entry
);

  logic                  held_valid;
  mwfe_pkg::word_entry_t held;

  assign push       = held_valid && !q_stat.full;
  assign push_entry = held;
  assign s_tready   = !held_valid || !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held_valid <= 1'b1;
    end else if (push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held.data_word <= s_tdata;
      held.last_word <= s_tlast;
      held.parity    <= ^s_tdata;
    end
  end

endmodule

/* rtl/mwfe_queue.sv */
// word queue between front end and serializer, memory with registered head
module mwfe_queue #(
  parameter int unsigned DEPTH = mwfe_pkg::FRAME_QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mwfe_pkg::word_entry_t push_entry,
  input  logic                  pop,
  output logic                  head_valid,
  output mwfe_pkg::word_entry_t head,
  output mwfe_pkg::queue_stat_t q_stat,
  output logic [CNT_W-1:0]      level
);

  mwfe_pkg::word_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level_next;
  logic             load;

  // refill the head register from memory when it is empty or leaving
  assign load         = (level != '0) && (!head_valid || pop);
  assign level_next   = level + CNT_W'(push) - CNT_W'(load);
  assign q_stat.full  = (level == CNT_W'(DEPTH));
  assign q_stat.empty = (level == '0) && !head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
    if (load) begin
      head <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      level      <= '0;
      head_valid <= 1'b0;
    end else begin
      level <= level_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (load) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/mwfe_back.sv */
// serializer: shifts out the 40 cells of each word into an output register
module mwfe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  mwfe_pkg::word_entry_t head,
  output logic                  pop,
  output mwfe_pkg::back_stat_t  b_stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  localparam logic [mwfe_pkg::CELL_CNT_W-1:0] LAST_IDX =
    mwfe_pkg::CELL_CNT_W'(mwfe_pkg::CELLS_PER_WORD - 1);

  logic                                  busy;
  logic [mwfe_pkg::CELL_CNT_W-1:0]       cell_cnt;
  logic [mwfe_pkg::CELLS_PER_WORD-1:0]   cells;
  logic                                  msg_end;
  logic                                  out_load;
  logic                                  finishing;
  logic                                  cell_level;

  assign out_load  = !m_tvalid || m_tready;
  assign finishing = busy && out_load && (cell_cnt == LAST_IDX);
  assign pop       = head_valid && (!busy || finishing);
  assign b_stat    = '{busy: busy, cell_cnt: cell_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cell_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= busy;
      end
      if (pop) begin
        busy     <= 1'b1;
        cell_cnt <= '0;
      end else if (finishing) begin
        busy     <= 1'b0;
        cell_cnt <= '0;
      end else if (busy && out_load) begin
        cell_cnt <= cell_cnt + 1'b1;
      end
    end
  end

  assign cell_level = cells[mwfe_pkg::CELLS_PER_WORD-1];

  always_ff @(posedge clk) begin
    if (busy && out_load) begin
      m_tdata <= {7'b0, cell_level};
      m_tlast <= (cell_cnt == LAST_IDX);
      m_tuser <= (cell_cnt == LAST_IDX) && msg_end;
    end
    if (pop) begin
      cells   <= mwfe_pkg::cell_frame(head.data_word, head.parity);
      msg_end <= head.last_word;
    end else if (busy && out_load) begin
      cells <= {cells[mwfe_pkg::CELLS_PER_WORD-2:0], 1'b0};
    end
  end

endmodule

/* dv/tb_manchester_word_frame_encoder.sv */
// testbench for the manchester word frame encoder: cell-by-cell check against a local predictor
`timescale 1ns / 100ps

module tb_manchester_word_frame_encoder;

  // a run well below this, even under the heaviest stalls
  localparam int unsigned CYCLE_LIMIT   = 500000;
  // covers any straggler cell still in the input stage, queue or serializer
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [5:0]  SYNC_LEVELS   = 6'b111000;

  // one expected line cell
  typedef struct packed {
    logic level;
    logic word_end;
    logic msg_end;
  } line_cell_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] data_word
  logic        s_tlast;   // last_word
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [0] cell_level, [7:1] zero
  logic        m_tlast;   // last_cell
  logic        m_tuser;   // end_of_message

  line_cell_t  pending_cells[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_cycles_left;

  manchester_word_frame_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run ceiling; reaching it means something hung
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // sink side: random stalls, or a long hold-off when one is requested
  initial begin : line_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_left > 0) begin
        m_tready <= 1'b0;
        hold_cycles_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // expected cells of one word, in line order
  task automatic encode_word_cells(input logic [15:0] word, input logic final_word);
    line_cell_t c;
    logic       par;
    par        = 1'b0;
    c.word_end = 1'b0;
    c.msg_end  = 1'b0;
    // sync: three high cells, three low
    for (int i = 5; i >= 0; i--) begin
      c.level = SYNC_LEVELS[i];
      pending_cells.push_back(c);
    end
    // data msb first; a 0 bit goes out as high-low, a 1 as low-high
    for (int i = 15; i >= 0; i--) begin
      par ^= word[i];
      c.level = ~word[i];
      pending_cells.push_back(c);
      c.level = word[i];
      pending_cells.push_back(c);
    end
    // parity bit coded the same way; its second cell closes the word
    c.level = ~par;
    pending_cells.push_back(c);
    c.level    = par;
    c.word_end = 1'b1;
    c.msg_end  = final_word;
    pending_cells.push_back(c);
  endtask

  // starts and ends at a falling edge; tvalid stays up after the transfer
  task automatic send_word(input logic [15:0] word, input logic final_word);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= final_word;
    do @(posedge clk); while (!s_tready);
    encode_word_cells(word, final_word);
    @(negedge clk);
  endtask

  // lower tvalid, then wait out every expected cell and a little more
  task automatic drain_line;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result checker: every cell transfer against the oldest expectation
  always @(posedge clk) begin
    line_cell_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell, expected none, actual tdata %h tlast %b tuser %b",
                 $time, m_tdata, m_tlast, m_tuser);
        mismatch_count++;
      end else begin
        want = pending_cells.pop_front();
        if (m_tdata !== {7'b0, want.level}) begin
          $display("%0t: cell_level mismatch, expected %h actual %h",
                   $time, {7'b0, want.level}, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== want.word_end) begin
          $display("%0t: last_cell mismatch, expected %b actual %b",
                   $time, want.word_end, m_tlast);
          mismatch_count++;
        end
        if (m_tuser !== want.msg_end) begin
          $display("%0t: end_of_message mismatch, expected %b actual %b",
                   $time, want.msg_end, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // field extremes, alternating patterns, single-bit words and both parities
  task automatic test_directed_words;
    logic [15:0] words[14];
    words = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hAAAA, 16'h5555, 16'h00AA,
              16'h80A9, 16'h8859, 16'h0055, 16'h7FFF, 16'hFFFE, 16'h0003, 16'h1234};
    // a one-word message first, then a long one closing on the last entry
    send_word(words[0], 1'b1);
    for (int i = 1; i < 14; i++) send_word(words[i], i == 13);
  endtask

  // sink holds off for a long stretch while words keep coming, so the queue fills
  task automatic test_queue_backpressure;
    drain_line();
    @(posedge clk);
    hold_cycles_left = HOLD_CYCLES;
    @(negedge clk);
    for (int i = 0; i < 20; i++) send_word(16'($urandom), (i % 5) == 4);
  endtask

  // well-formed messages of random length and content, with a little noise on tlast
  task automatic test_random_messages(input int unsigned n_words);
    int unsigned sent;
    int unsigned msg_len;
    logic [15:0] word;
    logic        final_word;
    sent = 0;
    while (sent < n_words) begin
      msg_len = $urandom_range(1, 6);
      for (int k = 0; k < msg_len; k++) begin
        case ($urandom_range(0, 19))
          0:       word = 16'h0000;
          1:       word = 16'hFFFF;
          default: word = 16'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 9) == 0) final_word = 1'($urandom_range(0, 1));
        else final_word = (k == msg_len - 1);
        send_word(word, final_word);
      end
      sent += msg_len;
    end
  endtask

  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tlast          = 1'b0;
    mismatch_count   = 0;
    hold_cycles_left = 0;
    sender_idle_pct  = 0;
    sink_stall_pct   = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_words();
    test_queue_backpressure();

    // idling phases: none, sender gaps, sink stalls, then both
    test_random_messages(105);
    sender_idle_pct = 66;
    test_random_messages(105);
    sender_idle_pct = 0;
    sink_stall_pct  = 66;
    test_random_messages(105);
    sender_idle_pct = 29;
    sink_stall_pct  = 29;
    test_random_messages(105);

    drain_line();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
